// ===== rtl/mboxrd_from_quoter_defines.svh =====
// assertion macros for the mboxrd from-line quoter
`ifndef MBOXRD_FROM_QUOTER_DEFINES_SVH
`define MBOXRD_FROM_QUOTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MBFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbfq_pkg.sv =====
// types, constants and byte tables shared by the mboxrd from-line quoter
package mbfq_pkg;

  localparam int JOB_W     = 26;
  localparam int POS_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // text job positions
  localparam logic [POS_W-1:0] POS_GT    = 5'd0;
  localparam logic [POS_W-1:0] POS_BYTE  = 5'd5;
  localparam logic [POS_W-1:0] POS_EXTRA = 5'd6;

  // status job positions that depend on flags
  localparam logic [POS_W-1:0] POS_SEEN     = 5'd8;
  localparam logic [POS_W-1:0] POS_OLD      = 5'd9;
  localparam logic [POS_W-1:0] POS_REPLIED  = 5'd21;
  localparam logic [POS_W-1:0] POS_TRASHED  = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAGGED  = 5'd23;

  localparam logic [JOB_W-1:0] STATUS_BASE_MASK = 26'b11_0001_1111_1111_1100_1111_1111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATUS_ENABLE = 3'd0,
    CFG_MARK_SEEN     = 3'd1,
    CFG_MARK_OLD      = 3'd2,
    CFG_MARK_REPLIED  = 3'd3,
    CFG_MARK_TRASHED  = 3'd4,
    CFG_MARK_FLAGGED  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic status_enable;
    logic mark_seen;
    logic mark_old;
    logic mark_replied;
    logic mark_trashed;
    logic mark_flagged;
  } cfg_t;

  typedef struct packed {
    logic             is_status;
    logic [JOB_W-1:0] mask;
    logic [7:0]       data;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

  function automatic logic [7:0] from_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6D;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic [JOB_W-1:0] held_mask(input logic [2:0] k);
    logic [JOB_W-1:0] m;
    case (k)
      3'd0:    m = 26'h0;
      3'd1:    m = 26'h2;
      3'd2:    m = 26'h6;
      3'd3:    m = 26'hE;
      default: m = 26'h1E;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] text_char(input logic [POS_W-1:0] pos, input logic [7:0] b);
    logic [7:0] c;
    case (pos)
      5'd0:    c = CH_GT;
      5'd1:    c = from_char(3'd0);
      5'd2:    c = from_char(3'd1);
      5'd3:    c = from_char(3'd2);
      5'd4:    c = from_char(3'd3);
      5'd5:    c = b;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

  // "Status: " R O nl "X-Status: " A D F nl nl
  function automatic logic [7:0] status_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = 8'h53;
      5'd1:    c = 8'h74;
      5'd2:    c = 8'h61;
      5'd3:    c = 8'h74;
      5'd4:    c = 8'h75;
      5'd5:    c = 8'h73;
      5'd6:    c = 8'h3A;
      5'd7:    c = CH_SPACE;
      5'd8:    c = 8'h52;
      5'd9:    c = 8'h4F;
      5'd10:   c = CH_NL;
      5'd11:   c = 8'h58;
      5'd12:   c = 8'h2D;
      5'd13:   c = 8'h53;
      5'd14:   c = 8'h74;
      5'd15:   c = 8'h61;
      5'd16:   c = 8'h74;
      5'd17:   c = 8'h75;
      5'd18:   c = 8'h73;
      5'd19:   c = 8'h3A;
      5'd20:   c = CH_SPACE;
      5'd21:   c = 8'h41;
      5'd22:   c = 8'h44;
      5'd23:   c = 8'h46;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mbfq_front.sv =====
// front end: line state tracking and classification of each input into an output job
module mbfq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbfq_pkg::in_item_t in_data,
  input  mbfq_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             job_valid,
  output mbfq_pkg::job_t   job
);

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PREFIX = 2'd1,
    PH_REST   = 2'd2,
    PH_REST_B = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] match_r, match_nxt;
  logic       hdr_open_r, hdr_open_nxt;
  logic       ended_nl_r, ended_nl_nxt;

  logic       accept;
  logic [2:0] k;
  logic [7:0] b;
  logic       is_nl;
  logic [mbfq_pkg::JOB_W-1:0] smask;

  assign accept = push && !q_full;
  assign k      = (match_r > 3'd4) ? 3'd4 : match_r;
  assign b      = in_data.data_byte;
  assign is_nl  = (b == mbfq_pkg::CH_NL);

  always_comb begin
    smask = mbfq_pkg::STATUS_BASE_MASK;
    smask[mbfq_pkg::POS_SEEN]    = cfg.mark_seen;
    smask[mbfq_pkg::POS_OLD]     = cfg.mark_old;
    smask[mbfq_pkg::POS_REPLIED] = cfg.mark_replied;
    smask[mbfq_pkg::POS_TRASHED] = cfg.mark_trashed;
    smask[mbfq_pkg::POS_FLAGGED] = cfg.mark_flagged;
  end

  always_comb begin
    phase_nxt     = phase_r;
    match_nxt     = match_r;
    hdr_open_nxt  = hdr_open_r;
    ended_nl_nxt  = ended_nl_r;
    job_valid     = 1'b0;
    job.is_status = 1'b0;
    job.mask      = '0;
    job.data      = b;
    if (in_data.command) begin
      job_valid = 1'b1;
      job.data  = mbfq_pkg::CH_NL;
      job.mask  = mbfq_pkg::held_mask(k);
      job.mask[mbfq_pkg::POS_BYTE]  = 1'b1;
      job.mask[mbfq_pkg::POS_EXTRA] = !ended_nl_r;
      phase_nxt     = PH_START;
      match_nxt     = 3'd0;
      hdr_open_nxt  = 1'b1;
      ended_nl_nxt  = 1'b0;
    end else begin
      ended_nl_nxt = is_nl;
      if (phase_r != PH_START && phase_r != PH_PREFIX) begin
        job_valid = 1'b1;
        job.mask[mbfq_pkg::POS_BYTE] = 1'b1;
        phase_nxt = is_nl ? PH_START : PH_REST;
      end else if (phase_r == PH_START && hdr_open_r && is_nl) begin
        job_valid = 1'b1;
        if (cfg.status_enable) begin
          job.is_status = 1'b1;
          job.mask      = smask;
        end else begin
          job.mask[mbfq_pkg::POS_BYTE] = 1'b1;
        end
        hdr_open_nxt = 1'b0;
      end else if (k == 3'd0 && b == mbfq_pkg::CH_GT) begin
        job_valid = 1'b1;
        job.mask[mbfq_pkg::POS_BYTE] = 1'b1;
        phase_nxt = PH_PREFIX;
      end else if (k < 3'd4 && b == mbfq_pkg::from_char(k)) begin
        match_nxt = k + 3'd1;
        phase_nxt = PH_PREFIX;
      end else if (k == 3'd4 && b == mbfq_pkg::CH_SPACE) begin
        job_valid = 1'b1;
        job.mask  = mbfq_pkg::held_mask(k);
        job.mask[mbfq_pkg::POS_GT]   = 1'b1;
        job.mask[mbfq_pkg::POS_BYTE] = 1'b1;
        match_nxt = 3'd0;
        phase_nxt = PH_REST;
      end else begin
        job_valid = 1'b1;
        job.mask  = mbfq_pkg::held_mask(k);
        job.mask[mbfq_pkg::POS_BYTE] = 1'b1;
        match_nxt = 3'd0;
        phase_nxt = is_nl ? PH_START : PH_REST;
      end
    end
    job_valid = job_valid && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      match_r     <= 3'd0;
      hdr_open_r  <= 1'b1;
      ended_nl_r  <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      match_r     <= match_nxt;
      hdr_open_r  <= hdr_open_nxt;
      ended_nl_r  <= ended_nl_nxt;
    end
  end

endmodule

// ===== rtl/mbfq_queue.sv =====
// small job queue between the front end and the byte sequencer
module mbfq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  mbfq_pkg::job_t   wr_job,
  input  logic             rd_en,
  output mbfq_pkg::job_t   rd_job,
  output mbfq_pkg::qstat_t stat
);

  mbfq_pkg::job_t mem_r [mbfq_pkg::Q_DEPTH];

  logic [mbfq_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mbfq_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  assign stat.full      = (count_r == mbfq_pkg::Q_CNT_W'(mbfq_pkg::Q_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign rd_job         = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/mbfq_back.sv =====
// back end: job to bytes in the output register, one per cycle unless pop stalls
module mbfq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  mbfq_pkg::job_t    q_job,
  output logic              q_take,
  output logic              busy,
  output logic              empty,
  input  logic              pop,
  output mbfq_pkg::out_item_t out_data
);

  logic                         cur_valid_r;
  mbfq_pkg::job_t               cur_r;
  logic                         out_valid_r;
  mbfq_pkg::out_item_t          out_r, out_nxt;

  logic                         pop_take;
  logic                         adv;
  logic [mbfq_pkg::POS_W-1:0]   pos;
  logic [mbfq_pkg::JOB_W-1:0]   rem;
  logic                         last;

  assign pop_take = pop && out_valid_r;
  assign adv      = cur_valid_r && (!out_valid_r || pop_take);
  assign rem      = cur_r.mask & (cur_r.mask - 1'b1);
  assign last     = (rem == '0);
  assign q_take   = q_not_empty && (!cur_valid_r || (adv && last));
  assign busy     = cur_valid_r;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    pos = '0;
    for (int i = mbfq_pkg::JOB_W - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) begin
        pos = mbfq_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    out_nxt.last     = last;
    out_nxt.out_byte = cur_r.is_status ? mbfq_pkg::status_char(pos)
                                       : mbfq_pkg::text_char(pos, cur_r.data);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
    if (q_take) begin
      cur_r <= q_job;
    end else if (adv) begin
      cur_r.mask <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_take) begin
        cur_valid_r <= 1'b1;
      end else if (adv && last) begin
        cur_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (pop_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mboxrd_from_quoter.sv =====
// top level of the mboxrd from-line quoter: config registers, front end, job queue, back end
// Takes one message byte or end-of-message marker per transfer and delivers the mboxrd-escaped
// stream one byte per transfer, with last set on the final byte that an input caused. Inputs
// are accepted one per cycle while the four-entry job queue has room; an input that only
// extends a held "From" match produces no bytes and no job. The back end sends one byte per
// cycle while its output is popped; an input causes one byte for a plain byte, up to six for
// a broken or quoted match and up to 26 for the inserted Status and X-Status lines. Sustained
// rate is one byte per cycle when each input yields one byte and pop is held high.
// Configuration writes take effect at once and should be made while the block is idle.
`include "mboxrd_from_quoter_defines.svh"

module mboxrd_from_quoter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  mbfq_pkg::in_item_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output mbfq_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mbfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data
);

  mbfq_pkg::cfg_t   cfg_r;
  mbfq_pkg::job_t   f_job, q_job;
  mbfq_pkg::qstat_t qstat;
  logic             f_job_valid;
  logic             q_take;
  logic             busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbfq_pkg::CFG_STATUS_ENABLE: cfg_r.status_enable <= cfg_data;
        mbfq_pkg::CFG_MARK_SEEN:     cfg_r.mark_seen     <= cfg_data;
        mbfq_pkg::CFG_MARK_OLD:      cfg_r.mark_old      <= cfg_data;
        mbfq_pkg::CFG_MARK_REPLIED:  cfg_r.mark_replied  <= cfg_data;
        mbfq_pkg::CFG_MARK_TRASHED:  cfg_r.mark_trashed  <= cfg_data;
        mbfq_pkg::CFG_MARK_FLAGGED:  cfg_r.mark_flagged  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = qstat.full;

  mbfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_full    (qstat.full),
    .job_valid (f_job_valid),
    .job       (f_job)
  );

  mbfq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_job_valid),
    .wr_job (f_job),
    .rd_en  (q_take),
    .rd_job (q_job),
    .stat   (qstat)
  );

  mbfq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (qstat.not_empty),
    .q_job       (q_job),
    .q_take      (q_take),
    .busy        (busy),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data)
  );

  `MBFQ_ASSERT_NOW(a_queue_no_overflow, f_job_valid, !qstat.full, "job queue overflow")
  `MBFQ_ASSERT_NEXT(a_back_progress, busy && empty, !empty, "back end stalled with empty output")
  `MBFQ_ASSERT_NEXT(a_eom_has_output, push && !full && in_data.command, qstat.not_empty || busy || !empty, "end of message produced no output")

endmodule

// ===== tb/tb_mboxrd_from_quoter.sv =====
// testbench for the mboxrd from-line quoter: message streams checked against a byte predictor
module tb_mboxrd_from_quoter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    SETTLE_CYCLES  = 40;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    HOLD_CYCLES    = 120;
  localparam logic  CMD_BYTE       = 1'b0;
  localparam logic  CMD_END        = 1'b1;
  localparam string FROM_TEXT      = "From ";

  typedef enum logic [1:0] {LINE_START, LINE_PREFIX, LINE_REST} line_pos_t;

  class escape_tracker;
    mbfq_pkg::cfg_t      flags;
    line_pos_t           line_pos;
    logic [2:0]          held;
    bit                  hdr_open;
    bit                  ended_nl;
    logic [7:0]          burst[$];
    mbfq_pkg::out_item_t expected_bytes[$];
    int                  errors;

    function new();
      flags     = '0;
      line_pos  = LINE_START;
      held      = '0;
      hdr_open  = 1'b1;
      ended_nl  = 1'b0;
      errors    = 0;
    endfunction

    function void apply_settings(mbfq_pkg::cfg_t c);
      flags = c;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    function void emit_text(string s);
      for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
    endfunction

    function void emit_held(int k);
      for (int i = 0; i < k; i++) burst.push_back(FROM_TEXT[i]);
    endfunction

    function void note_input(mbfq_pkg::in_item_t it);
      logic [7:0]          b;
      int                  k;
      mbfq_pkg::out_item_t e;
      b = it.data_byte;
      k = (held > 3'd4) ? 4 : int'(held);
      burst.delete();
      if (it.command == CMD_END) begin
        emit_held(k);
        if (!ended_nl) burst.push_back(mbfq_pkg::CH_NL);
        burst.push_back(mbfq_pkg::CH_NL);
        line_pos  = LINE_START;
        held      = '0;
        hdr_open  = 1'b1;
        ended_nl  = 1'b0;
      end else begin
        ended_nl = (b == mbfq_pkg::CH_NL);
        if (line_pos == LINE_REST) begin
          burst.push_back(b);
          line_pos = (b == mbfq_pkg::CH_NL) ? LINE_START : LINE_REST;
        end else if (line_pos == LINE_START && hdr_open && b == mbfq_pkg::CH_NL) begin
          if (flags.status_enable) begin
            emit_text("Status: ");
            if (flags.mark_seen) burst.push_back("R");
            if (flags.mark_old) burst.push_back("O");
            burst.push_back(mbfq_pkg::CH_NL);
            emit_text("X-Status: ");
            if (flags.mark_replied) burst.push_back("A");
            if (flags.mark_trashed) burst.push_back("D");
            if (flags.mark_flagged) burst.push_back("F");
            burst.push_back(mbfq_pkg::CH_NL);
          end
          hdr_open = 1'b0;
          burst.push_back(mbfq_pkg::CH_NL);
        end else if (k == 0 && b == mbfq_pkg::CH_GT) begin
          burst.push_back(b);
          line_pos = LINE_PREFIX;
        end else if (k < 4 && b == FROM_TEXT[k]) begin
          held     = 3'(k + 1);
          line_pos = LINE_PREFIX;
        end else if (k == 4 && b == mbfq_pkg::CH_SPACE) begin
          burst.push_back(mbfq_pkg::CH_GT);
          emit_held(4);
          burst.push_back(mbfq_pkg::CH_SPACE);
          held     = '0;
          line_pos = LINE_REST;
        end else begin
          emit_held(k);
          burst.push_back(b);
          held     = '0;
          line_pos = (b == mbfq_pkg::CH_NL) ? LINE_START : LINE_REST;
        end
      end
      foreach (burst[i]) begin
        e.out_byte = burst[i];
        e.last     = (i == burst.size() - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_byte(mbfq_pkg::out_item_t got);
      mbfq_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte, expected none, actual %h last %b",
                 $time, got.out_byte, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  mbfq_pkg::in_item_t             in_data = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  mbfq_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [mbfq_pkg::CFG_IDX_W-1:0] cfg_index = mbfq_pkg::CFG_STATUS_ENABLE;
  logic                           cfg_data = 1'b0;

  escape_tracker      tracker;
  mbfq_pkg::in_item_t stim[$];
  int                 stall_pct = 0;
  bit                 hold_pop = 1'b0;
  int                 quiet_cycles = 0;

  mboxrd_from_quoter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pop <= rst_n && !hold_pop && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) tracker.note_input(in_data);
      if (pop && !empty) tracker.check_byte(out_data);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_byte(logic [7:0] b);
    mbfq_pkg::in_item_t it;
    it.command   = CMD_BYTE;
    it.data_byte = b;
    stim.push_back(it);
  endtask

  task automatic add_end();
    mbfq_pkg::in_item_t it;
    it.command   = CMD_END;
    it.data_byte = 8'($urandom_range(255));
    stim.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_from(int n);
    for (int i = 0; i < n; i++) add_byte(FROM_TEXT[i]);
  endtask

  task automatic add_gts();
    repeat ($urandom_range(2)) add_byte(mbfq_pkg::CH_GT);
  endtask

  task automatic add_plain(int n);
    repeat (n) add_byte(8'($urandom_range(8'h7E, 8'h20)));
  endtask

  task automatic add_line();
    case ($urandom_range(9))
      0, 1, 2: add_plain($urandom_range(6));
      3, 4: begin
        add_gts();
        add_from(5);
        add_plain($urandom_range(4));
      end
      5, 6: begin
        add_gts();
        add_from($urandom_range(4, 1));
        add_byte(8'($urandom_range(255)));
        add_plain($urandom_range(3));
      end
      7: repeat ($urandom_range(5, 1)) add_byte(8'($urandom_range(255)));
      8: begin
        add_gts();
        add_from(4);
      end
      default: begin
        add_plain(2);
        add_from(5);
      end
    endcase
  endtask

  task automatic add_message();
    repeat ($urandom_range(3)) begin
      add_line();
      add_byte(mbfq_pkg::CH_NL);
    end
    if ($urandom_range(9) < 8) add_byte(mbfq_pkg::CH_NL);
    repeat ($urandom_range(3)) begin
      add_line();
      add_byte(mbfq_pkg::CH_NL);
    end
    case ($urandom_range(3))
      0: begin
        add_gts();
        add_from($urandom_range(4, 1));
      end
      1: add_line();
      default: ;
    endcase
    add_end();
  endtask

  task automatic write_settings(mbfq_pkg::cfg_t c);
    mbfq_pkg::cfg_idx_t reg_order[6];
    logic               reg_value[6];
    reg_order = '{mbfq_pkg::CFG_STATUS_ENABLE, mbfq_pkg::CFG_MARK_SEEN,
                  mbfq_pkg::CFG_MARK_OLD, mbfq_pkg::CFG_MARK_REPLIED,
                  mbfq_pkg::CFG_MARK_TRASHED, mbfq_pkg::CFG_MARK_FLAGGED};
    reg_value = '{c.status_enable, c.mark_seen, c.mark_old,
                  c.mark_replied, c.mark_trashed, c.mark_flagged};
    tracker.apply_settings(c);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= reg_value[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_items(int idle_pct);
    foreach (stim[i]) begin
      while ($urandom_range(99) < idle_pct) begin
        push <= 1'b0;
        @(negedge clk);
      end
      push    <= 1'b1;
      in_data <= stim[i];
      @(posedge clk);
      while (full) @(posedge clk);
      @(negedge clk);
    end
    push <= 1'b0;
    stim.delete();
  endtask

  task automatic drain();
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int             idle_pcts[4];
    int             stall_pcts[4];
    int             targets[4];
    mbfq_pkg::cfg_t setting;
    idle_pcts  = '{0, 52, 0, 31};
    stall_pcts = '{0, 0, 52, 31};
    targets    = '{100, 70, 70, 70};
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      stall_pct = stall_pcts[p];
      case (p)
        0:       setting = '1;
        1:       setting = '0;
        default: setting = mbfq_pkg::cfg_t'(6'($urandom_range(63)));
      endcase
      if (p == 3) setting.status_enable = 1'b1;
      write_settings(setting);
      if (p == 0) begin
        // empty message, quoted and broken matches, header end, end inside a match
        add_end();
        add_text("From \n>From");
        add_byte(8'h00);
        add_text("\n\n>From ");
        add_byte(8'hFF);
        add_end();
        add_text("Fro");
        add_end();
      end
      while (stim.size() < targets[p]) add_message();
      if (p == 0) begin
        fork
          begin
            @(posedge clk);
            hold_pop = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_pop = 1'b0;
          end
          send_items(idle_pcts[p]);
        join
      end else begin
        send_items(idle_pcts[p]);
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mbfq_pkg.sv
rtl/mbfq_front.sv
rtl/mbfq_queue.sv
rtl/mbfq_back.sv
rtl/mboxrd_from_quoter.sv
tb/tb_mboxrd_from_quoter.sv
